### hw/rtl/lfu_pkg.sv
`default_nettype none

package lfu_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 31;
   localparam int COUNT_W = 32;
   localparam int CSR_W   = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_PUT = 1'b1;

   typedef struct packed {
      logic               action;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] read_value;
      logic               evicted;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
   } entry_type;

endpackage

`default_nettype wire

### hw/rtl/lfu_cache_table_core.sv
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    lfu_pkg::req_type  (action, key, value)
// rsp_      out        rsp_valid/stall    lfu_pkg::rsp_type  (found, read_value, evicted)
// csr_      in         csr_write_enable   csr_write_data     (capacity)
//
// After acceptance, one pass over the entry memory finds the key and the victim; for a hit or
// a put, the entry is written and a second read-modify-write pass over the rank memory reorders
// recency, while a get miss goes straight to the result. The next transaction is accepted once
// the result has been posted.
// Reset empties the cache at once (with N the occupancy count, the filled slots are 0 .. N-1).
// A transaction only stalls at its end if the previous result has not yet been taken.
`default_nettype none

module lfu_cache_table_core #(
   parameter int CAPACITY = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lfu_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lfu_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [lfu_pkg::CSR_W-1:0] csr_write_data
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OW = $clog2(CAPACITY + 1);
   localparam int EW = (OW > lfu_pkg::CSR_W) ? OW : lfu_pkg::CSR_W;
   localparam logic [OW-1:0] OCC_MAX = OW'(CAPACITY);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

   lfu_pkg::entry_type main_mem [CAPACITY];
   logic [IW-1:0]      rank_mem [CAPACITY];

   state_type             state_ff, state_in;
   logic [lfu_pkg::CSR_W-1:0] capacity_ff, capacity_in;
   logic [OW-1:0]         occ_ff, occ_in;
   logic [OW-1:0]         cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   lfu_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   lfu_pkg::req_type      req_ff, req_in;
   logic                  hit_found_ff, hit_found_in;
   logic [IW-1:0]         hit_idx_ff, hit_idx_in;
   logic [IW-1:0]         hit_rank_ff, hit_rank_in;
   lfu_pkg::entry_type    hit_entry_ff, hit_entry_in;
   logic                  vic_found_ff, vic_found_in;
   logic [IW-1:0]         vic_idx_ff, vic_idx_in;
   logic [IW-1:0]         vic_rank_ff, vic_rank_in;
   logic [lfu_pkg::COUNT_W-1:0] vic_count_ff, vic_count_in;
   logic [IW-1:0]         tgt_ff, tgt_in;
   logic [OW-1:0]         old_ff, old_in;
   lfu_pkg::rsp_type      res_ff, res_in;

   lfu_pkg::entry_type    main_rd_ff;
   logic [IW-1:0]         rank_rd_ff;

   logic                  main_we;
   lfu_pkg::entry_type    main_wdata;
   logic                  rank_we;
   logic [IW-1:0]         rank_wdata;
   logic [OW-1:0]         prev_cnt;
   logic [IW-1:0]         e_idx;
   logic [IW-1:0]         rd_addr;
   logic [EW-1:0]         cap_nz;
   logic                  full;

   assign prev_cnt  = cnt_ff - 1'b1;
   assign e_idx     = prev_cnt[IW-1:0];
   assign rd_addr   = cnt_ff[IW-1:0];
   assign cap_nz    = (capacity_ff == '0) ? EW'(1) : EW'(capacity_ff);
   assign full      = (EW'(occ_ff) >= cap_nz) || (occ_ff == OCC_MAX);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      capacity_in  = capacity_ff;
      occ_in       = occ_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_in       = req_ff;
      hit_found_in = hit_found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rank_in  = hit_rank_ff;
      hit_entry_in = hit_entry_ff;
      vic_found_in = vic_found_ff;
      vic_idx_in   = vic_idx_ff;
      vic_rank_in  = vic_rank_ff;
      vic_count_in = vic_count_ff;
      tgt_in       = tgt_ff;
      old_in       = old_ff;
      res_in       = res_ff;
      main_we      = 1'b0;
      main_wdata   = main_rd_ff;
      rank_we      = 1'b0;
      rank_wdata   = rank_rd_ff;

      if (csr_write_enable) begin
         capacity_in = csr_write_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in       = req_data;
               cnt_in       = '0;
               hit_found_in = 1'b0;
               vic_found_in = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff != '0) begin
               if (!hit_found_ff && main_rd_ff.key == req_ff.key) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = e_idx;
                  hit_rank_in  = rank_rd_ff;
                  hit_entry_in = main_rd_ff;
               end
               if (!vic_found_ff || main_rd_ff.count < vic_count_ff ||
                   (main_rd_ff.count == vic_count_ff && rank_rd_ff > vic_rank_ff)) begin
                  vic_found_in = 1'b1;
                  vic_idx_in   = e_idx;
                  vic_rank_in  = rank_rd_ff;
                  vic_count_in = main_rd_ff.count;
               end
            end
            if (cnt_ff == occ_ff) begin
               state_in = ST_DECIDE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            cnt_in = '0;
            res_in = '0;
            if (hit_found_ff) begin
               tgt_in           = hit_idx_ff;
               old_in           = OW'(hit_rank_ff);
               main_we          = 1'b1;
               main_wdata.key   = req_ff.key;
               main_wdata.value = (req_ff.action == lfu_pkg::ACTION_PUT) ?
                                  req_ff.value : hit_entry_ff.value;
               main_wdata.count = (hit_entry_ff.count == lfu_pkg::COUNT_MAX) ?
                                  hit_entry_ff.count : hit_entry_ff.count + 1'b1;
               res_in.found     = 1'b1;
               res_in.read_value = (req_ff.action == lfu_pkg::ACTION_PUT) ?
                                   '0 : hit_entry_ff.value;
               state_in         = ST_UPDATE;
            end else if (req_ff.action == lfu_pkg::ACTION_PUT) begin
               if (full) begin
                  tgt_in         = vic_idx_ff;
                  old_in         = OW'(vic_rank_ff);
                  res_in.evicted = 1'b1;
               end else begin
                  tgt_in = occ_ff[IW-1:0];
                  old_in = occ_ff;
                  occ_in = occ_ff + 1'b1;
               end
               main_we          = 1'b1;
               main_wdata.key   = req_ff.key;
               main_wdata.value = req_ff.value;
               main_wdata.count = lfu_pkg::COUNT_ONE;
               state_in         = ST_UPDATE;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_UPDATE: begin
            if (cnt_ff != '0) begin
               rank_we = 1'b1;
               if (e_idx == tgt_ff) begin
                  rank_wdata = '0;
               end else if (OW'(rank_rd_ff) < old_ff) begin
                  rank_wdata = rank_rd_ff + 1'b1;
               end else begin
                  rank_wdata = rank_rd_ff;
               end
            end
            if (cnt_ff == occ_ff) begin
               state_in = ST_RESULT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= lfu_pkg::CSR_W'(16);
         occ_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         occ_ff       <= occ_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      req_ff       <= req_in;
      hit_found_ff <= hit_found_in;
      hit_idx_ff   <= hit_idx_in;
      hit_rank_ff  <= hit_rank_in;
      hit_entry_ff <= hit_entry_in;
      vic_found_ff <= vic_found_in;
      vic_idx_ff   <= vic_idx_in;
      vic_rank_ff  <= vic_rank_in;
      vic_count_ff <= vic_count_in;
      tgt_ff       <= tgt_in;
      old_ff       <= old_in;
      res_ff       <= res_in;
   end

   always_ff @(posedge clock) begin
      if (main_we) begin
         main_mem[tgt_in] <= main_wdata;
      end
      main_rd_ff <= main_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[e_idx] <= rank_wdata;
      end
      rank_rd_ff <= rank_mem[rd_addr];
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_MAX)
      else $error("occupancy beyond the slot count");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_SCAN)
      else $error("accepted transaction did not start the scan");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && occ_ff != $past(occ_ff)) |->
         (occ_ff == $past(occ_ff) + 1'b1 && $past(state_ff) == ST_DECIDE))
      else $error("occupancy changed outside an insertion");

   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.found && rsp_data_ff.evicted))
      else $error("eviction reported on a hit");

   a_value_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.read_value != '0) |-> rsp_data_ff.found)
      else $error("value returned without a hit");

endmodule

`default_nettype wire
